FILE: sv/rmm_pkg.sv
// Shared types, sizes and codes for the running median multiset block.
package rmm_pkg;

  localparam int CAPACITY   = 64;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);
  localparam int IDX_BITS   = $clog2(CAPACITY);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0]        count_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [1:0]                   func_t;
  typedef logic [1:0]                   err_t;
  typedef logic [1:0]                   op_t;

  localparam count_t FULL_COUNT = count_t'(CAPACITY);

  // Input function codes
  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_DELETE = 2'd1;
  localparam func_t FUNC_POP    = 2'd2;

  // Error codes
  localparam err_t ERR_OK       = 2'd0;
  localparam err_t ERR_EMPTY    = 2'd1;
  localparam err_t ERR_NOTFOUND = 2'd2;
  localparam err_t ERR_FULL     = 2'd3;

  // Chain operations broadcast to every cell
  localparam op_t OP_HOLD   = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_DELETE = 2'd2;
  localparam op_t OP_POP    = 2'd3;

  // Operand broadcast to every cell for one transaction
  typedef struct packed {
    value_t value;
    count_t count;
    idx_t   pos;
  } cmd_t;

endpackage

FILE: sv/running_median_multiset.sv
// After a transaction is accepted, its result is built by the chain update (S_EXEC) and then
// by the median read into the output register (S_MED), which waits while a result is stalled.
// A new transaction is taken only in S_IDLE, once the previous result has been loaded; the
// chain update and the median select in S_MED both depend on the entry count left by the update.
// A new transaction is taken while the previous result still waits at the output.
// Reset clears the entry count, the control state and the output valid; cell contents
// are left as they are and are only read below the entry count.
module running_median_multiset (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rmm_pkg::func_t         func,
  input  rmm_pkg::value_t        value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rmm_pkg::value_t        median,
  output rmm_pkg::value_t        popped,
  output rmm_pkg::count_t        count,
  output rmm_pkg::err_t          error
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MED  = 2'd2;

  logic [1:0]      state;
  logic [1:0]      state_next;
  rmm_pkg::func_t  op_func;
  rmm_pkg::cmd_t   cmd;
  rmm_pkg::count_t entry_count;
  rmm_pkg::count_t entry_count_next;
  rmm_pkg::value_t popped_val;
  rmm_pkg::err_t   err_code;

  rmm_pkg::value_t             cell_value [rmm_pkg::CAPACITY];
  logic [rmm_pkg::CAPACITY-1:0] cell_gt;
  logic [rmm_pkg::CAPACITY-1:0] cell_match;

  logic            accept;
  logic            found;
  logic            empty;
  logic            full;
  rmm_pkg::op_t    op;
  rmm_pkg::err_t   err_next;
  rmm_pkg::count_t cnt_m1;
  rmm_pkg::idx_t   mid_idx;
  rmm_pkg::value_t mid_value;
  logic            out_load;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Build the sorted chain
  for (genvar i = 0; i < rmm_pkg::CAPACITY; i++) begin : g_cell
    rmm_pkg::value_t left_v;
    rmm_pkg::value_t right_v;
    logic            left_g;

    if (i == 0) begin : g_first
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_mid_left
      assign left_v = cell_value[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == rmm_pkg::CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_right
      assign right_v = cell_value[i+1];
    end

    rmm_cell u_cell (
      .clk         (clk),
      .cell_index  (rmm_pkg::idx_t'(i)),
      .op          (op),
      .cmd         (cmd),
      .left_value  (left_v),
      .left_gt     (left_g),
      .right_value (right_v),
      .value       (cell_value[i]),
      .gt          (cell_gt[i]),
      .match       (cell_match[i])
    );
  end

  // Decide the chain operation and the error code for the held transaction
  always_comb begin
    found            = |cell_match;
    empty            = (entry_count == '0);
    full             = (entry_count == rmm_pkg::FULL_COUNT);
    op               = rmm_pkg::OP_HOLD;
    err_next         = rmm_pkg::ERR_OK;
    entry_count_next = entry_count;
    case (op_func)
      rmm_pkg::FUNC_INSERT: begin
        if (full) begin
          err_next = rmm_pkg::ERR_FULL;
        end else begin
          op               = rmm_pkg::OP_INSERT;
          entry_count_next = entry_count + 1'b1;
        end
      end
      rmm_pkg::FUNC_DELETE: begin
        if (empty) begin
          err_next = rmm_pkg::ERR_EMPTY;
        end else if (!found) begin
          err_next = rmm_pkg::ERR_NOTFOUND;
        end else begin
          op               = rmm_pkg::OP_DELETE;
          entry_count_next = entry_count - 1'b1;
        end
      end
      rmm_pkg::FUNC_POP: begin
        if (empty) begin
          err_next = rmm_pkg::ERR_EMPTY;
        end else begin
          op               = rmm_pkg::OP_POP;
          entry_count_next = entry_count - 1'b1;
        end
      end
      default: begin
        op = rmm_pkg::OP_HOLD;
      end
    endcase
    if (state != S_EXEC) begin
      op               = rmm_pkg::OP_HOLD;
      entry_count_next = entry_count;
    end
  end

  // Select the lower median entry; also serves the pop position before the update
  always_comb begin
    cnt_m1    = entry_count - 1'b1;
    mid_idx   = rmm_pkg::idx_t'(cnt_m1 >> 1);
    mid_value = cell_value[mid_idx];
  end

  assign out_load = (state == S_MED) && !(out_valid && out_stall);

  // Sequence accept, chain update and median read
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_MED;
      end
      S_MED: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the transaction operands and the results of the update
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func   <= func;
      cmd.value <= value;
      cmd.count <= entry_count;
      cmd.pos   <= mid_idx;
    end
    if (state == S_EXEC) begin
      err_code   <= err_next;
      popped_val <= (op == rmm_pkg::OP_POP) ? mid_value : '0;
    end
    if (out_load) begin
      median <= (entry_count == '0) ? '0 : mid_value;
      popped <= popped_val;
      count  <= entry_count;
      error  <= err_code;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= rmm_pkg::FULL_COUNT)
    else $error("entry count above capacity");

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> state == S_MED)
    else $error("update stage lasted more than one cycle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted transaction did not reach the update stage");

  a_full_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == rmm_pkg::ERR_FULL |-> count == rmm_pkg::FULL_COUNT)
    else $error("full error reported with room left");

  a_empty_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && error == rmm_pkg::ERR_EMPTY |-> count == '0)
    else $error("empty error reported with entries stored");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    state != S_EXEC |=> entry_count == $past(entry_count))
    else $error("entry count changed outside the update stage");
`endif

endmodule

FILE: sv/rmm_cell.sv
// One cell of the sorted chain: holds one entry and shifts toward either neighbor.
module rmm_cell (
  input  logic            clk,
  input  rmm_pkg::idx_t   cell_index,
  input  rmm_pkg::op_t    op,
  input  rmm_pkg::cmd_t   cmd,
  input  rmm_pkg::value_t left_value,
  input  logic            left_gt,
  input  rmm_pkg::value_t right_value,
  output rmm_pkg::value_t value,
  output logic            gt,
  output logic            match
);

  logic            occupied;
  rmm_pkg::value_t value_next;

  // Compare the held entry against the broadcast operand; empty cells act as +infinity
  always_comb begin
    occupied = rmm_pkg::count_t'(cell_index) < cmd.count;
    gt       = !occupied || (value > cmd.value);
    match    = occupied && (value == cmd.value);
  end

  // Select the next entry: hold, take the operand, or shift from a neighbor
  always_comb begin
    value_next = value;
    case (op)
      rmm_pkg::OP_INSERT: begin
        if (gt) begin
          value_next = left_gt ? left_value : cmd.value;
        end
      end
      rmm_pkg::OP_DELETE: begin
        if (occupied && !(value < cmd.value)) begin
          value_next = right_value;
        end
      end
      rmm_pkg::OP_POP: begin
        if (cell_index >= cmd.pos) begin
          value_next = right_value;
        end
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

FILE: sim/rmm_checker.sv
// Checker for the running median multiset: predicts each result and compares it in order.
module rmm_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  rmm_pkg::func_t  func,
  input  rmm_pkg::value_t value,
  input  logic            out_valid,
  input  logic            out_stall,
  input  rmm_pkg::value_t median,
  input  rmm_pkg::value_t popped,
  input  rmm_pkg::count_t count,
  input  rmm_pkg::err_t   error,
  output int              fail_count,
  output int              results_owed,
  output int              checked,
  output int              peak_fill,
  output int              full_hits,
  output int              rejects
);

  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    rmm_pkg::value_t median;
    rmm_pkg::value_t popped;
    rmm_pkg::count_t count;
    rmm_pkg::err_t   error;
  } median_rec_t;

  // Shadow multiset, ascending by signed value; only entries below fill are live
  rmm_pkg::value_t sorted_vals [rmm_pkg::CAPACITY];
  int              fill;
  median_rec_t     pending_results [$];
  median_rec_t     want_rec;
  median_rec_t     next_rec;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_PRINTED) begin
      $display("[rmm_checker] result %0d: %s", checked, msg);
    end
  endtask

  // Drop one entry and close the gap
  function automatic void drop_at(input int pos);
    for (int i = pos; i + 1 < fill; i++) begin
      sorted_vals[i] = sorted_vals[i + 1];
    end
    fill--;
  endfunction

  // Apply one transaction to the shadow multiset and build the result it yields
  function automatic median_rec_t update_multiset(input rmm_pkg::func_t f,
                                                  input rmm_pkg::value_t v);
    median_rec_t r;
    int          pos;
    int          hit;
    r.popped = '0;
    r.error  = rmm_pkg::ERR_OK;
    case (f)
      rmm_pkg::FUNC_INSERT: begin
        if (fill >= rmm_pkg::CAPACITY) begin
          r.error = rmm_pkg::ERR_FULL;
        end else begin
          pos = fill;
          while (pos > 0 && sorted_vals[pos - 1] > v) begin
            sorted_vals[pos] = sorted_vals[pos - 1];
            pos--;
          end
          sorted_vals[pos] = v;
          fill++;
        end
      end
      rmm_pkg::FUNC_DELETE: begin
        if (fill == 0) begin
          r.error = rmm_pkg::ERR_EMPTY;
        end else begin
          hit = -1;
          for (int i = 0; i < fill; i++) begin
            if (hit < 0 && sorted_vals[i] == v) hit = i;
          end
          if (hit < 0) r.error = rmm_pkg::ERR_NOTFOUND;
          else drop_at(hit);
        end
      end
      rmm_pkg::FUNC_POP: begin
        if (fill == 0) begin
          r.error = rmm_pkg::ERR_EMPTY;
        end else begin
          pos = (fill - 1) / 2;
          r.popped = sorted_vals[pos];
          drop_at(pos);
        end
      end
      default: begin
        // unused code: leave the store alone
      end
    endcase
    r.median = (fill == 0) ? rmm_pkg::value_t'(0) : sorted_vals[(fill - 1) / 2];
    r.count  = rmm_pkg::count_t'(fill);
    return r;
  endfunction

  // Compare results as they leave, then predict for transactions as they enter
  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      pending_results.delete();
      results_owed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with no transaction pending (median %h count %0d)",
                                    median, count));
        end else begin
          want_rec = pending_results.pop_front();
          results_owed--;
          if (median !== want_rec.median)
            report_mismatch($sformatf("median expected %h got %h", want_rec.median, median));
          if (popped !== want_rec.popped)
            report_mismatch($sformatf("popped expected %h got %h", want_rec.popped, popped));
          if (count !== want_rec.count)
            report_mismatch($sformatf("count expected %0d got %0d", want_rec.count, count));
          if (error !== want_rec.error)
            report_mismatch($sformatf("error expected %0d got %0d", want_rec.error, error));
          checked++;
        end
      end
      if (in_valid && !in_stall) begin
        next_rec = update_multiset(func, value);
        pending_results.push_back(next_rec);
        results_owed++;
        if (fill > peak_fill) peak_fill = fill;
        if (next_rec.error == rmm_pkg::ERR_FULL) full_hits++;
        if (next_rec.error != rmm_pkg::ERR_OK) rejects++;
      end
    end
  end

endmodule

FILE: sim/tb_running_median_multiset.sv
// Testbench top for the running median multiset: stimulus, receiver stalls and verdict.
module tb_running_median_multiset;

  typedef enum logic [1:0] {PH_GROW, PH_SHRINK, PH_MIXED} phase_t;

  localparam rmm_pkg::func_t  FUNC_NOP       = 2'd3;
  localparam int              RANDOM_ITEMS   = 1850;
  localparam int              WATCHDOG_LIMIT = 4000;
  localparam int              HOLD_START     = 1500;
  localparam int              HOLD_LEN       = 400;
  localparam int              DRAIN_CYCLES   = 12;
  localparam rmm_pkg::value_t VMIN = {1'b1, {(rmm_pkg::VALUE_BITS-1){1'b0}}};
  localparam rmm_pkg::value_t VMAX = {1'b0, {(rmm_pkg::VALUE_BITS-1){1'b1}}};

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  rmm_pkg::func_t  func;
  rmm_pkg::value_t value;
  logic            out_valid;
  logic            out_stall;
  rmm_pkg::value_t median;
  rmm_pkg::value_t popped;
  rmm_pkg::count_t count;
  rmm_pkg::err_t   error;

  int              fail_count;
  int              results_owed;
  int              checked;
  int              peak_fill;
  int              full_hits;
  int              rejects;
  int              sent;
  int              directed_sent;
  int              burst_left;
  bit              eager;
  int              idle_cycles;
  rmm_pkg::value_t pool [8];

  always #5 clk = ~clk;

  running_median_multiset dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .median    (median),
    .popped    (popped),
    .count     (count),
    .error     (error)
  );

  rmm_checker order_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median       (median),
    .popped       (popped),
    .count        (count),
    .error        (error),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .checked      (checked),
    .peak_fill    (peak_fill),
    .full_hits    (full_hits),
    .rejects      (rejects)
  );

  // Offer one transaction at the falling edge and hold it until accepted
  task automatic send_op(input rmm_pkg::func_t f, input rmm_pkg::value_t v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!eager && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Mix pool values (for duplicates and hits), extremes and full-range noise
  function automatic rmm_pkg::value_t pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return ($urandom_range(0, 1) != 0) ? VMIN : VMAX;
    if (roll <= 5) return pool[$urandom_range(0, 7)];
    return rmm_pkg::value_t'($urandom);
  endfunction

  function automatic void refresh_pool();
    for (int i = 0; i < 8; i++) begin
      if ($urandom_range(0, 4) < 3) begin
        pool[i] = rmm_pkg::value_t'($urandom_range(0, 40)) - rmm_pkg::value_t'(20);
      end else begin
        pool[i] = rmm_pkg::value_t'($urandom);
      end
    end
  endfunction

  // Stimulus: directed corner cases, then phased random traffic
  initial begin
    phase_t          ph;
    int              phase_left;
    int              counted;
    int              roll;
    rmm_pkg::func_t  f;
    rmm_pkg::value_t v;
    rst        = 1'b1;
    in_valid   = 1'b0;
    func       = rmm_pkg::FUNC_INSERT;
    value      = '0;
    burst_left = 0;
    eager      = 1'b0;
    sent       = 0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // empty store, unused code, extremes, duplicates, absent delete, drain to empty
    send_op(rmm_pkg::FUNC_POP, '0);
    send_op(rmm_pkg::FUNC_DELETE, rmm_pkg::value_t'(5));
    send_op(FUNC_NOP, rmm_pkg::value_t'(9));
    send_op(rmm_pkg::FUNC_INSERT, VMAX);
    send_op(rmm_pkg::FUNC_INSERT, VMIN);
    send_op(rmm_pkg::FUNC_INSERT, '0);
    send_op(rmm_pkg::FUNC_INSERT, rmm_pkg::value_t'(-1));
    send_op(rmm_pkg::FUNC_INSERT, VMAX);
    send_op(FUNC_NOP, VMIN);
    send_op(rmm_pkg::FUNC_DELETE, rmm_pkg::value_t'(12345));
    send_op(rmm_pkg::FUNC_DELETE, VMAX);
    send_op(rmm_pkg::FUNC_INSERT, VMIN);
    send_op(rmm_pkg::FUNC_POP, VMAX);
    send_op(rmm_pkg::FUNC_POP, '0);
    send_op(rmm_pkg::FUNC_DELETE, VMIN);
    send_op(rmm_pkg::FUNC_INSERT, rmm_pkg::value_t'(32'h5555_5555));
    send_op(rmm_pkg::FUNC_INSERT, rmm_pkg::value_t'(32'haaaa_aaaa));
    send_op(rmm_pkg::FUNC_POP, '0);
    send_op(rmm_pkg::FUNC_POP, '1);
    send_op(rmm_pkg::FUNC_POP, '0);
    send_op(rmm_pkg::FUNC_POP, '0);
    send_op(rmm_pkg::FUNC_POP, '0);
    send_op(rmm_pkg::FUNC_DELETE, rmm_pkg::value_t'(32'h5555_5555));
    directed_sent = sent;

    // random phases: grow toward full, shrink toward empty, or mix
    counted    = 0;
    phase_left = 0;
    ph         = PH_GROW;
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        roll = $urandom_range(0, 9);
        ph = (roll < 4) ? PH_GROW : (roll < 7) ? PH_SHRINK : PH_MIXED;
        phase_left = (ph == PH_GROW) ? $urandom_range(80, 200) : $urandom_range(40, 150);
        eager = ($urandom_range(0, 3) == 0);
        refresh_pool();
      end
      roll = $urandom_range(0, 99);
      case (ph)
        PH_GROW: begin
          f = (roll < 80) ? rmm_pkg::FUNC_INSERT :
              (roll < 90) ? rmm_pkg::FUNC_DELETE : rmm_pkg::FUNC_POP;
        end
        PH_SHRINK: begin
          f = (roll < 15) ? rmm_pkg::FUNC_INSERT :
              (roll < 55) ? rmm_pkg::FUNC_DELETE : rmm_pkg::FUNC_POP;
        end
        default: begin
          f = (roll < 40) ? rmm_pkg::FUNC_INSERT :
              (roll < 70) ? rmm_pkg::FUNC_DELETE : rmm_pkg::FUNC_POP;
        end
      endcase
      if ($urandom_range(0, 49) == 0) f = FUNC_NOP;
      if (f == rmm_pkg::FUNC_DELETE && $urandom_range(0, 9) < 7) v = pool[$urandom_range(0, 7)];
      else v = pick_value();
      send_op(f, v);
      if (f != FUNC_NOP) counted++;
      phase_left--;
    end
    in_valid <= 1'b0;

    // drain and give the verdict
    wait (results_owed == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d transactions (%0d directed) and checked %0d results in order.",
             sent, directed_sent, checked);
    $display("Store peaked at %0d of %0d entries; %0d rejected, %0d on a full store.",
             peak_fill, rmm_pkg::CAPACITY, rejects, full_hits);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver: switch among random stall patterns, with one long hold-off
  initial begin
    int cyc;
    int mode;
    out_stall = 1'b0;
    cyc       = 0;
    mode      = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN) begin
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cyc % 7 < 3);
        endcase
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: running_median_multiset.f
sv/rmm_pkg.sv
sv/rmm_cell.sv
sv/running_median_multiset.sv
sim/rmm_checker.sv
sim/tb_running_median_multiset.sv
